// ----- src/assert_macros.svh -----
// Assertion macros used by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- src/bale_pkg.sv -----
// Package for the bounded array list engine: defaults, command and status codes.
`timescale 1ns / 1ps
`default_nettype none
package bale_pkg;
	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REMOVE_EQ  = 3'd4,
		CMD_REVERSE    = 3'd5,
		CMD_READ       = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;
endpackage
`default_nettype wire

// ----- src/bale_ram.sv -----
// Generic RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- src/bounded_array_list_engine.sv -----
// Top level of the bounded array list engine: command sequencer around one RAM.
// Push back, pop back, code 7, an out-of-range read and any command that leaves the list
// as is go straight to FINISH; a read in range passes RD_WAIT; push front shifts entries
// up, then writes the head; pop front and remove compact in CMP; reverse swaps pairs. The
// next transfer is taken the cycle after the result register loads; a stalled result holds
// FINISH. Reset clears count and control; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bounded_array_list_engine import bale_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [VALUE_W-1:0]  value,
	input  wire logic [INDEX_W-1:0]  index,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_W-1:0]       count,
	output logic [VALUE_W-1:0]       read_data,
	output logic [COUNT_W-1:0]       removed_count
);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

	typedef enum logic [3:0] {
		IDLE, RD_WAIT, PF_SHIFT, PF_HEAD, CMP, REV_PRIME, REV_WLO, REV_WHI, FINISH
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         hi_q;
	logic [CW-1:0]         wp_q;
	logic [CW-1:0]         rem_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] tmp_q;
	logic                  drop_first_q;
	status_t               res_status_q;
	logic [DATA_WIDTH-1:0] res_rdata_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic [VALUE_W-1:0]    out_rdata_q;
	logic [COUNT_W-1:0]    out_removed_q;

	logic                  we_c;
	logic [AW-1:0]         waddr_c;
	logic [DATA_WIDTH-1:0] wdata_c;
	logic [AW-1:0]         raddr_c;
	logic [DATA_WIDTH-1:0] rd;

	logic                  accept_c;
	logic                  full_c;
	logic                  empty_c;
	logic                  idx_ok_c;
	logic                  cmp_last_c;
	logic                  cmp_keep_c;
	logic                  rev_more_c;
	logic                  out_free_c;
	state_t                acc_state_c;
	status_t               acc_status_c;

	bale_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(wdata_c),
		.raddr(raddr_c),
		.rdata(rd)
	);

	assign in_stall   = (state_q != IDLE);
	assign accept_c   = in_valid && (state_q == IDLE);
	assign full_c     = (count_q == CW'(CAPACITY));
	assign empty_c    = (count_q == '0);
	assign idx_ok_c   = (CMPW'(index) < CMPW'(count_q));
	assign cmp_last_c = ((CW'(ptr_q) + CW'(1)) == count_q);
	assign cmp_keep_c = drop_first_q ? (ptr_q != '0) : (rd != val_q);
	// another swap follows when the next pair still has lo < hi
	assign rev_more_c = (({1'b0, ptr_q} + (AW + 1)'(2)) < {1'b0, hi_q});
	assign out_free_c = !out_valid_q || !out_stall;

	// next state and status taken at the accepting edge
	always_comb begin
		acc_state_c  = FINISH;
		acc_status_c = ST_OK;
		case (cmd_t'(cmd))
			CMD_PUSH_FRONT: begin
				if (full_c) begin
					acc_status_c = ST_FULL;
				end else if (empty_c) begin
					acc_state_c = PF_HEAD;
				end else begin
					acc_state_c = PF_SHIFT;
				end
			end
			CMD_PUSH_BACK: begin
				if (full_c) begin
					acc_status_c = ST_FULL;
				end
			end
			CMD_POP_FRONT: begin
				if (empty_c) begin
					acc_status_c = ST_EMPTY;
				end else begin
					acc_state_c = CMP;
				end
			end
			CMD_POP_BACK: begin
				if (empty_c) begin
					acc_status_c = ST_EMPTY;
				end
			end
			CMD_REMOVE_EQ: begin
				if (!empty_c) begin
					acc_state_c = CMP;
				end
			end
			CMD_REVERSE: begin
				if (count_q > CW'(1)) begin
					acc_state_c = REV_PRIME;
				end
			end
			CMD_READ: begin
				if (idx_ok_c) begin
					acc_state_c = RD_WAIT;
				end else begin
					acc_status_c = ST_RANGE;
				end
			end
			default: acc_state_c = FINISH;
		endcase
	end

	// RAM port control
	always_comb begin
		we_c    = 1'b0;
		waddr_c = '0;
		wdata_c = rd;
		raddr_c = '0;
		case (state_q)
			IDLE: begin
				case (cmd_t'(cmd))
					CMD_PUSH_BACK: begin
						we_c    = accept_c && !full_c;
						waddr_c = count_q[AW-1:0];
						wdata_c = DATA_WIDTH'(value);
					end
					CMD_PUSH_FRONT: raddr_c = AW'(count_q - CW'(1));
					CMD_READ:       raddr_c = AW'(index);
					default:        raddr_c = '0;
				endcase
			end
			PF_SHIFT: begin
				we_c    = 1'b1;
				waddr_c = ptr_q + AW'(1);
				raddr_c = ptr_q - AW'(1);
			end
			PF_HEAD: begin
				we_c    = 1'b1;
				waddr_c = '0;
				wdata_c = val_q;
			end
			CMP: begin
				we_c    = cmp_keep_c;
				waddr_c = wp_q[AW-1:0];
				raddr_c = ptr_q + AW'(1);
			end
			REV_PRIME: raddr_c = hi_q;
			REV_WLO: begin
				we_c    = 1'b1;
				waddr_c = ptr_q;
				raddr_c = ptr_q + AW'(1);
			end
			REV_WHI: begin
				we_c    = 1'b1;
				waddr_c = hi_q;
				wdata_c = tmp_q;
				raddr_c = hi_q - AW'(1);
			end
			default: we_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept_c) begin
						val_q        <= DATA_WIDTH'(value);
						res_status_q <= acc_status_c;
						res_rdata_q  <= '0;
						rem_q        <= '0;
						wp_q         <= '0;
						ptr_q        <= (cmd_t'(cmd) == CMD_PUSH_FRONT) ?
							AW'(count_q - CW'(1)) : '0;
						hi_q         <= AW'(count_q - CW'(1));
						drop_first_q <= (cmd_t'(cmd) == CMD_POP_FRONT);
						state_q      <= acc_state_c;
						case (cmd_t'(cmd))
							CMD_PUSH_BACK: begin
								if (!full_c) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_POP_BACK: begin
								if (!empty_c) begin
									count_q <= count_q - CW'(1);
								end
							end
							default: count_q <= count_q;
						endcase
					end
				end
				RD_WAIT: begin
					res_rdata_q <= rd;
					state_q     <= FINISH;
				end
				PF_SHIFT: begin
					ptr_q <= ptr_q - AW'(1);
					if (ptr_q == '0) begin
						state_q <= PF_HEAD;
					end
				end
				PF_HEAD: begin
					count_q <= count_q + CW'(1);
					state_q <= FINISH;
				end
				CMP: begin
					// rd holds the entry at ptr_q; kept entries slide down to wp_q
					if (cmp_keep_c) begin
						wp_q <= wp_q + CW'(1);
					end else if (!drop_first_q) begin
						rem_q <= rem_q + CW'(1);
					end
					ptr_q <= ptr_q + AW'(1);
					if (cmp_last_c) begin
						count_q <= cmp_keep_c ? (wp_q + CW'(1)) : wp_q;
						state_q <= FINISH;
					end
				end
				REV_PRIME: begin
					tmp_q   <= rd;
					state_q <= REV_WLO;
				end
				REV_WLO: begin
					state_q <= REV_WHI;
				end
				REV_WHI: begin
					tmp_q <= rd;
					if (rev_more_c) begin
						ptr_q   <= ptr_q + AW'(1);
						hi_q    <= hi_q - AW'(1);
						state_q <= REV_WLO;
					end else begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free_c) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= res_status_q;
						out_count_q   <= COUNT_W'(count_q);
						out_rdata_q   <= VALUE_W'(res_rdata_q);
						out_removed_q <= COUNT_W'(rem_q);
						state_q       <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign count         = out_count_q;
	assign read_data     = out_rdata_q;
	assign removed_count = out_removed_q;

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(CAPACITY))
	`ASSERT_PROP(a_result_from_finish, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == FINISH))
	`ASSERT_PROP(a_cmp_write_behind_read, clk, arst_n, (state_q == CMP) |-> (wp_q <= CW'(ptr_q)))
	`ASSERT_PROP(a_rev_order, clk, arst_n, (state_q == REV_WLO) |-> (ptr_q < hi_q))
endmodule
`default_nettype wire

// ----- tb/bale_list_checker.sv -----
// Checker for the bounded array list engine: tracks the list, predicts and compares results.
`timescale 1ns / 1ps
module bale_list_checker import bale_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [CMD_W-1:0]    cmd,
	input  wire logic [VALUE_W-1:0]  value,
	input  wire logic [INDEX_W-1:0]  index,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [STATUS_W-1:0] status,
	input  wire logic [COUNT_W-1:0]  count,
	input  wire logic [VALUE_W-1:0]  read_data,
	input  wire logic [COUNT_W-1:0]  removed_count,
	output int                       fail_count,
	output int                       pending,
	output int                       checked_count,
	output int                       full_rejects
);
	localparam int EXP_DEPTH = 8;

	typedef struct packed {
		status_t              st;
		logic [COUNT_W-1:0]   cnt;
		logic [VALUE_W-1:0]   rd;
		logic [COUNT_W-1:0]   rm;
	} list_result_t;

	logic [VALUE_W-1:0] list_words [DEF_CAPACITY];
	int                 list_len = 0;
	list_result_t       awaited_results [EXP_DEPTH];
	int                 exp_wr = 0;
	int                 exp_rd = 0;
	int                 mismatches = 0;
	int                 results_seen = 0;
	int                 full_seen = 0;

	assign fail_count    = mismatches;
	assign pending       = exp_wr - exp_rd;
	assign checked_count = results_seen;
	assign full_rejects  = full_seen;

	// close the gap at pos by moving every later entry down one place
	function automatic void close_gap(int pos);
		int k;
		for (k = pos; k + 1 < list_len; k++)
			list_words[k] = list_words[k + 1];
	endfunction

	function automatic list_result_t apply_command(logic [CMD_W-1:0] op,
			logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] ix);
		list_result_t r;
		int k;
		int lo;
		int hi;
		logic [VALUE_W-1:0] t;
		r.st = ST_OK;
		r.cnt = '0;
		r.rd = '0;
		r.rm = '0;
		case (op)
			CMD_PUSH_FRONT: begin
				if (list_len >= DEF_CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					for (k = list_len; k > 0; k--)
						list_words[k] = list_words[k - 1];
					list_words[0] = v;
					list_len++;
				end
			end
			CMD_PUSH_BACK: begin
				if (list_len >= DEF_CAPACITY) begin
					r.st = ST_FULL;
				end else begin
					list_words[list_len] = v;
					list_len++;
				end
			end
			CMD_POP_FRONT: begin
				if (list_len == 0) begin
					r.st = ST_EMPTY;
				end else begin
					close_gap(0);
					list_len--;
				end
			end
			CMD_POP_BACK: begin
				if (list_len == 0)
					r.st = ST_EMPTY;
				else
					list_len--;
			end
			CMD_REMOVE_EQ: begin
				k = 0;
				while (k < list_len) begin
					if (list_words[k] == v) begin
						close_gap(k);
						list_len--;
						r.rm++;
					end else begin
						k++;
					end
				end
			end
			CMD_REVERSE: begin
				lo = 0;
				hi = list_len;
				while (lo + 1 < hi) begin
					hi--;
					t = list_words[lo];
					list_words[lo] = list_words[hi];
					list_words[hi] = t;
					lo++;
				end
			end
			CMD_READ: begin
				if (ix < list_len)
					r.rd = list_words[ix];
				else
					r.st = ST_RANGE;
			end
			default: ;
		endcase
		r.cnt = list_len[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_len = 0;
			exp_wr = 0;
			exp_rd = 0;
		end else begin
			if (in_valid && !in_stall) begin
				want = apply_command(cmd, value, index);
				if (want.st == ST_FULL)
					full_seen++;
				if (exp_wr - exp_rd >= EXP_DEPTH) begin
					$display("%0t: too many results outstanding: expected at most %0d actual %0d",
						$time, EXP_DEPTH, exp_wr - exp_rd + 1);
					mismatches++;
				end else begin
					awaited_results[exp_wr % EXP_DEPTH] = want;
					exp_wr++;
				end
			end
			if (out_valid && !out_stall) begin
				if (exp_wr == exp_rd) begin
					$display("%0t: unexpected result: status %0d count %0d data %h removed %0d",
						$time, status, count, read_data, removed_count);
					mismatches++;
				end else begin
					want = awaited_results[exp_rd % EXP_DEPTH];
					exp_rd++;
					results_seen++;
					if (status !== want.st) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, want.st, status);
						mismatches++;
					end
					if (count !== want.cnt) begin
						$display("%0t: count mismatch: expected %0d actual %0d",
							$time, want.cnt, count);
						mismatches++;
					end
					if (read_data !== want.rd) begin
						$display("%0t: read_data mismatch: expected %h actual %h",
							$time, want.rd, read_data);
						mismatches++;
					end
					if (removed_count !== want.rm) begin
						$display("%0t: removed_count mismatch: expected %0d actual %0d",
							$time, want.rm, removed_count);
						mismatches++;
					end
				end
			end
		end
	end
endmodule

// ----- tb/tb_bounded_array_list_engine.sv -----
// Testbench top for the bounded array list engine: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps
module tb_bounded_array_list_engine;
	import bale_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 1650;
	localparam int CALM_TAIL    = 250;
	localparam int SEGMENT_LEN  = 24;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;

	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd = '0;
	logic [VALUE_W-1:0]  value = '0;
	logic [INDEX_W-1:0]  index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic [VALUE_W-1:0]  read_data;
	logic [COUNT_W-1:0]  removed_count;

	int fail_count;
	int pending;
	int checked_count;
	int full_rejects;

	bit idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int sent_total = 0;
	int cycle_count = 0;

	bounded_array_list_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .value(value), .index(index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .count(count), .read_data(read_data),
		.removed_count(removed_count)
	);

	bale_list_checker list_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .value(value), .index(index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .count(count), .read_data(read_data),
		.removed_count(removed_count),
		.fail_count(fail_count), .pending(pending),
		.checked_count(checked_count), .full_rejects(full_rejects)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("status: fail");
			$finish;
		end
	end

	// result side: short random stall bursts, plus one long hold-off on request
	always begin
		@(posedge clk);
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			out_stall <= 1'b1;
			repeat (LONG_HOLD) @(posedge clk);
			out_stall <= 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	// present one command and hold it until the transfer completes
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
			input logic [INDEX_W-1:0] ix);
		in_valid <= 1'b1;
		cmd <= c;
		value <= v;
		index <= ix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_total++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// mostly a small pool so remove finds matches, sometimes a full random word
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1: return '0;
			2, 3: return '1;
			4: return 32'h5A5A_A5A5;
			5: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(int mode);
		int push_pct;
		int pop_pct;
		int r;
		int s;
		push_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 15 : 35;
		pop_pct  = (mode == MODE_FILL) ? 5 : (mode == MODE_DRAIN) ? 45 : 20;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		if (r < push_pct + pop_pct)
			return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
		s = $urandom_range(0, 19);
		if (s < 10)
			return CMD_READ;
		if (s < 15)
			return CMD_REMOVE_EQ;
		if (s < 19)
			return CMD_REVERSE;
		return CMD_UNUSED;
	endfunction

	initial begin
		int mode;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-list cases, the unused code, then word extremes and reads around the count
		send_cmd(CMD_POP_FRONT, '0, '0);
		send_cmd(CMD_POP_BACK, '0, '0);
		send_cmd(CMD_REMOVE_EQ, '0, '0);
		send_cmd(CMD_REVERSE, '0, '0);
		send_cmd(CMD_READ, '0, '0);
		send_cmd(CMD_UNUSED, '1, '1);
		send_cmd(CMD_PUSH_BACK, '1, '0);
		send_cmd(CMD_PUSH_FRONT, '0, '0);
		send_cmd(CMD_PUSH_BACK, '0, '1);
		send_cmd(CMD_PUSH_BACK, 32'h8000_0001, '0);
		send_cmd(CMD_READ, '0, 4'd0);
		send_cmd(CMD_READ, '0, 4'd1);
		send_cmd(CMD_READ, '0, 4'd3);
		send_cmd(CMD_READ, '0, 4'd4);
		send_cmd(CMD_READ, '0, 4'd15);
		send_cmd(CMD_REVERSE, '0, '0);
		send_cmd(CMD_READ, '0, 4'd0);
		send_cmd(CMD_REMOVE_EQ, '0, '0);
		send_cmd(CMD_UNUSED, '0, '0);
		send_cmd(CMD_POP_FRONT, '0, '0);
		send_cmd(CMD_POP_BACK, '0, '0);
		send_cmd(CMD_READ, '0, 4'd0);

		mode = MODE_FILL;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % SEGMENT_LEN == 0) begin
				mode = $urandom_range(MODE_FILL, MODE_MIXED);
				idle_on = (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			end
			// park the result side while commands keep coming, so the input backs up
			if (n == 500)
				long_hold_req = 1'b1;
			send_cmd(pick_cmd(mode), pick_value(), INDEX_W'($urandom_range(0, 15)));
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d commands: empty and full list edges, all codes incl. unused,",
			sent_total);
		$display("fill/drain/mixed runs; %0d results compared, %0d full-list pushes refused",
			checked_count, full_rejects);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/bale_pkg.sv
src/bale_ram.sv
src/bounded_array_list_engine.sv
tb/bale_list_checker.sv
tb/tb_bounded_array_list_engine.sv
